// ===== rtl/core/bafifo_pkg.sv =====
package bafifo_pkg;

    localparam logic [1:0] FUNC_HEADER = 2'd0;
    localparam logic [1:0] FUNC_DATA   = 2'd1;
    localparam logic [1:0] FUNC_READ   = 2'd2;

    localparam logic [1:0] KIND_STATUS = 2'd0;
    localparam logic [1:0] KIND_BYTE   = 2'd1;
    localparam logic [1:0] KIND_EMPTY  = 2'd2;

    localparam int LEN_W  = 11;
    localparam int BYTE_W = 8;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RD_ISSUE,
        ST_RD_LOAD
    } state_t;

    typedef struct packed {
        logic [1:0]        kind;
        logic              admitted;
        logic [BYTE_W-1:0] read_byte;
        logic              last;
        logic [LEN_W-1:0]  fill_level;
    } result_t;

endpackage

// ===== rtl/core/bafifo_mem.sv =====
module bafifo_mem
    import bafifo_pkg::*;
#(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
)
(
    input  logic              clk,
    input  logic              we,
    input  logic [AW-1:0]     waddr,
    input  logic [BYTE_W-1:0] wdata,
    input  logic              re,
    input  logic [AW-1:0]     raddr,
    output logic [BYTE_W-1:0] rdata
);

    logic [BYTE_W-1:0] mem [DEPTH];
    logic [BYTE_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/bafifo_ctrl.sv =====
module bafifo_ctrl
    import bafifo_pkg::*;
#(
    parameter int DEPTH    = 1024,
    parameter int MAX_READ = 64,
    parameter int AW       = 10
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [1:0]        func,
    input  logic [LEN_W-1:0]  burst_length,
    input  logic [BYTE_W-1:0] data_byte,
    input  logic              out_free,
    output logic              res_load,
    output result_t           res,
    output logic              mem_we,
    output logic [AW-1:0]     mem_waddr,
    output logic [BYTE_W-1:0] mem_wdata,
    output logic              mem_re,
    output logic [AW-1:0]     mem_raddr,
    input  logic [BYTE_W-1:0] mem_rdata
);

    localparam int FW = $clog2(DEPTH + 1);
    localparam int CW = (FW > 11) ? FW + 1 : 12;
    localparam int RW = $clog2(MAX_READ + 1);

    state_t            state_reg, state_next;
    logic [AW-1:0]     wptr_reg, wptr_next;
    logic [AW-1:0]     rptr_reg, rptr_next;
    logic [FW-1:0]     fill_reg, fill_next;
    logic [LEN_W-1:0]  brem_reg, brem_next;
    logic              bacc_reg, bacc_next;
    logic [RW-1:0]     cnt_reg, cnt_next;

    logic              accept;
    logic              hdr_ok;
    logic [CW-1:0]     len_cw;
    logic [CW-1:0]     fill_cw;
    logic [CW-1:0]     lim_cw;
    logic [CW-1:0]     n_cw;
    logic [CW-1:0]     fill_dec_cw;
    logic [AW-1:0]     wptr_inc;
    logic [AW-1:0]     rptr_inc;

    assign in_stall    = (state_reg != ST_IDLE) || !out_free;
    assign accept      = in_valid && !in_stall;
    assign len_cw      = CW'(burst_length);
    assign fill_cw     = CW'(fill_reg);
    assign fill_dec_cw = fill_cw - CW'(1);
    assign hdr_ok      = (len_cw + fill_cw) <= CW'(DEPTH);
    assign lim_cw      = (len_cw > CW'(MAX_READ)) ? CW'(MAX_READ) : len_cw;
    assign n_cw        = (lim_cw > fill_cw) ? fill_cw : lim_cw;
    assign wptr_inc    = (wptr_reg == AW'(DEPTH - 1)) ? '0 : wptr_reg + AW'(1);
    assign rptr_inc    = (rptr_reg == AW'(DEPTH - 1)) ? '0 : rptr_reg + AW'(1);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && func == FUNC_READ && n_cw != '0)
                begin
                    state_next = ST_RD_ISSUE;
                end
            end
            ST_RD_ISSUE:
            begin
                state_next = ST_RD_LOAD;
            end
            ST_RD_LOAD:
            begin
                if (out_free && cnt_reg == RW'(1))
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        wptr_next          = wptr_reg;
        rptr_next          = rptr_reg;
        fill_next          = fill_reg;
        brem_next          = brem_reg;
        bacc_next          = bacc_reg;
        cnt_next           = cnt_reg;
        res_load           = 1'b0;
        res.kind           = KIND_STATUS;
        res.admitted       = 1'b0;
        res.read_byte      = '0;
        res.last           = 1'b1;
        res.fill_level     = fill_cw[LEN_W-1:0];
        mem_we             = 1'b0;
        mem_waddr          = wptr_reg;
        mem_wdata          = data_byte;
        mem_re             = 1'b0;
        mem_raddr          = rptr_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (func)
                        FUNC_HEADER:
                        begin
                            brem_next    = burst_length;
                            bacc_next    = hdr_ok && burst_length != '0;
                            res_load     = 1'b1;
                            res.admitted = hdr_ok;
                        end
                        FUNC_DATA:
                        begin
                            if (brem_reg != '0)
                            begin
                                if (bacc_reg && fill_cw != CW'(DEPTH))
                                begin
                                    mem_we    = 1'b1;
                                    wptr_next = wptr_inc;
                                    fill_next = fill_reg + FW'(1);
                                end
                                brem_next = brem_reg - LEN_W'(1);
                                if (brem_reg == LEN_W'(1))
                                begin
                                    bacc_next = 1'b0;
                                end
                            end
                        end
                        FUNC_READ:
                        begin
                            if (n_cw == '0)
                            begin
                                res_load = 1'b1;
                                res.kind = KIND_EMPTY;
                            end
                            else
                            begin
                                cnt_next = RW'(n_cw);
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_RD_ISSUE:
            begin
                mem_re    = 1'b1;
                rptr_next = rptr_inc;
            end
            ST_RD_LOAD:
            begin
                if (out_free)
                begin
                    res_load       = 1'b1;
                    res.kind       = KIND_BYTE;
                    res.read_byte  = mem_rdata;
                    res.last       = cnt_reg == RW'(1);
                    res.fill_level = fill_dec_cw[LEN_W-1:0];
                    fill_next      = fill_reg - FW'(1);
                    cnt_next       = cnt_reg - RW'(1);
                    if (cnt_reg != RW'(1))
                    begin
                        mem_re    = 1'b1;
                        rptr_next = rptr_inc;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            fill_reg  <= '0;
            brem_reg  <= '0;
            bacc_reg  <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            fill_reg  <= fill_next;
            brem_reg  <= brem_next;
            bacc_reg  <= bacc_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

// ===== rtl/core/burst_admission_byte_fifo.sv =====
// Circular byte FIFO with all-or-nothing burst admission. A write header
// (func 0) answers with one status item telling whether its whole burst fits
// the free space; the data bytes (func 1) that follow are stored only for an
// admitted burst and yield no item. A read request (func 2) returns up to
// MAX_READ bytes from the head, one item per byte with last on the final one,
// or a single empty item. Headers, data bytes and empty reads stall the input
// only while the output is busy. A read stalls the input until its last byte
// is loaded: the first address goes to the byte memory, whose data arrives in
// the next cycle, then one byte per cycle while the output is not stalled. The
// byte memory needs no clearing after reset; DEPTH need not be a power of two.
module burst_admission_byte_fifo
    import bafifo_pkg::*;
#(
    parameter int DEPTH    = 1024,
    parameter int MAX_READ = 64
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [1:0]        func,
    input  logic [LEN_W-1:0]  burst_length,
    input  logic [BYTE_W-1:0] data_byte,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [1:0]        kind,
    output logic              admitted,
    output logic [BYTE_W-1:0] read_byte,
    output logic              last,
    output logic [LEN_W-1:0]  fill_level
);

    localparam int AW = $clog2(DEPTH);

    logic              out_valid_reg;
    result_t           res_reg;
    logic              out_free;
    logic              res_load;
    result_t           res;
    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [BYTE_W-1:0] mem_wdata;
    logic              mem_re;
    logic [AW-1:0]     mem_raddr;
    logic [BYTE_W-1:0] mem_rdata;

    assign out_free = !out_valid_reg || !out_stall;

    bafifo_ctrl #(
        .DEPTH    (DEPTH),
        .MAX_READ (MAX_READ),
        .AW       (AW)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .func         (func),
        .burst_length (burst_length),
        .data_byte    (data_byte),
        .out_free     (out_free),
        .res_load     (res_load),
        .res          (res),
        .mem_we       (mem_we),
        .mem_waddr    (mem_waddr),
        .mem_wdata    (mem_wdata),
        .mem_re       (mem_re),
        .mem_raddr    (mem_raddr),
        .mem_rdata    (mem_rdata)
    );

    bafifo_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            res_reg <= res;
        end
    end

    assign out_valid  = out_valid_reg;
    assign kind       = res_reg.kind;
    assign admitted   = res_reg.admitted;
    assign read_byte  = res_reg.read_byte;
    assign last       = res_reg.last;
    assign fill_level = res_reg.fill_level;

endmodule

// ===== rtl/core/bafifo_checker.sv =====
module bafifo_checker
    import bafifo_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_stall,
    input logic [1:0]        func,
    input logic              out_valid,
    input logic              out_stall,
    input logic [1:0]        kind,
    input logic              admitted,
    input logic [BYTE_W-1:0] read_byte,
    input logic              last,
    input logic [LEN_W-1:0]  fill_level
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(kind) && $stable(read_byte)
            && $stable(last) && $stable(fill_level))
        else $error("stalled output item changed");

    a_hdr_status: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && func == FUNC_HEADER
            |=> out_valid && kind == KIND_STATUS && last)
        else $error("header did not yield a status item");

    a_field_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind != KIND_STATUS |-> !admitted
            && (kind == KIND_BYTE || (read_byte == '0 && last)))
        else $error("result fields inconsistent with kind");

    a_read_drain: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == KIND_BYTE && !last |-> in_stall)
        else $error("input taken while a read was still draining");

endmodule

bind burst_admission_byte_fifo bafifo_checker u_bafifo_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .func       (func),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .kind       (kind),
    .admitted   (admitted),
    .read_byte  (read_byte),
    .last       (last),
    .fill_level (fill_level)
);
